[hdl/unary_led_clock_controller_assert.svh]
// Assertion macros for the clock controller RTL.
// With SYNTH defined every macro expands to nothing.
`ifndef UNARY_LED_CLOCK_CONTROLLER_ASSERT_SVH
`define UNARY_LED_CLOCK_CONTROLLER_ASSERT_SVH

`ifndef SYNTH

// The condition holds at every clock edge outside reset.
`define ULCC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("clock controller check failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define ULCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clock controller sequence check failed");

`else

`define ULCC_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ULCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/ulcc_pkg.sv]
`timescale 1ns / 1ps

package ulcc_pkg;

    // Request codes.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_PRESS = 2'd1;
    localparam logic [1:0] REQ_SCAN  = 2'd2;

    // Mode codes.
    localparam logic [1:0] MODE_RUN  = 2'd0;
    localparam logic [1:0] MODE_HOUR = 2'd1;
    localparam logic [1:0] MODE_TENS = 2'd2;
    localparam logic [1:0] MODE_ONES = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_AUTO_SLEEP = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE   = 2'd1;
    localparam logic [1:0] CFG_LONG_PRESS = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] AUTO_SLEEP_RESET = 8'd10;
    localparam logic [7:0] DEBOUNCE_RESET   = 8'd5;
    localparam logic [7:0] LONG_PRESS_RESET = 8'd200;

    localparam logic [3:0] LAST_SLOT = 4'd8;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] press_length;
        logic [3:0] slot;
        logic       blink_phase;
    } t_item;

    typedef struct packed {
        logic [7:0] auto_sleep_seconds;
        logic [7:0] debounce_min;
        logic [7:0] long_press_min;
    } t_cfg;

    // Display state as seen by the scan decoder.
    typedef struct packed {
        logic       hour_tens_lit;
        logic [8:0] hour_mask;
        logic [5:0] minute_tens_mask;
        logic [8:0] minute_ones_mask;
        logic       asleep;
        logic [1:0] set_mode;
    } t_disp;

    // Status after the current item.
    typedef struct packed {
        logic       asleep;
        logic [1:0] set_mode;
    } t_status;

    typedef struct packed {
        logic [7:0] port1_level;
        logic [7:0] port2_level;
        logic [7:0] port1_drive;
        logic [7:0] port2_drive;
        logic [3:0] dwell;
    } t_scan;

    // Charlieplex tables: {port1 level, port2 level, port1 drive, port2 drive}.
    function automatic logic [31:0] hour_entry(input logic [3:0] idx);
        logic [31:0] e;
        unique case (idx)
            4'd0:    e = 32'h40_00_40_20;
            4'd1:    e = 32'h00_10_00_30;
            4'd2:    e = 32'h00_08_00_0C;
            4'd3:    e = 32'h00_20_00_30;
            4'd4:    e = 32'h00_08_00_18;
            4'd5:    e = 32'h00_20_40_20;
            4'd6:    e = 32'h40_00_C0_00;
            4'd7:    e = 32'h00_10_00_18;
            4'd8:    e = 32'h00_04_00_0C;
            default: e = 32'h0;
        endcase
        return e;
    endfunction

    function automatic logic [31:0] tens_entry(input logic [2:0] idx);
        logic [31:0] e;
        unique case (idx)
            3'd0:    e = 32'h02_00_06_00;
            3'd1:    e = 32'h01_00_03_00;
            3'd2:    e = 32'h04_00_0C_00;
            3'd3:    e = 32'h08_00_0C_00;
            3'd4:    e = 32'h10_00_18_00;
            3'd5:    e = 32'h04_00_06_00;
            default: e = 32'h0;
        endcase
        return e;
    endfunction

    function automatic logic [31:0] ones_entry(input logic [3:0] idx);
        logic [31:0] e;
        unique case (idx)
            4'd0:    e = 32'h20_00_20_01;
            4'd1:    e = 32'h00_02_00_06;
            4'd2:    e = 32'h00_01_00_03;
            4'd3:    e = 32'h10_00_30_00;
            4'd4:    e = 32'h00_01_20_01;
            4'd5:    e = 32'h00_04_00_06;
            4'd6:    e = 32'h20_00_30_00;
            4'd7:    e = 32'h00_02_00_03;
            4'd8:    e = 32'h08_00_18_00;
            default: e = 32'h0;
        endcase
        return e;
    endfunction

endpackage

[hdl/ulcc_scan.sv]
`timescale 1ns / 1ps

module ulcc_scan (
    input  logic [3:0]     i_slot,
    input  logic           i_blink_phase,
    input  ulcc_pkg::t_disp i_disp,
    output ulcc_pkg::t_scan o_scan
);
    import ulcc_pkg::*;

    logic        show_hour;
    logic        show_tens;
    logic        show_ones;
    logic [31:0] acc;
    logic [3:0]  dwell;

    assign show_hour = (i_disp.set_mode == MODE_RUN)
                     || (i_blink_phase && i_disp.set_mode == MODE_HOUR);
    assign show_tens = (i_disp.set_mode == MODE_RUN)
                     || (i_blink_phase && i_disp.set_mode == MODE_TENS);
    assign show_ones = (i_disp.set_mode == MODE_RUN)
                     || (i_blink_phase && i_disp.set_mode == MODE_ONES);

    always_comb begin
        acc   = 32'h0;
        dwell = 4'd0;
        if (!i_disp.asleep && i_slot <= LAST_SLOT) begin
            // The hour tens lamp sits on the first three slots.
            if (show_hour && i_disp.hour_tens_lit && i_slot < 4'd3) begin
                acc = 32'h80_00_C0_00;
            end
            if (show_hour && i_disp.hour_mask[i_slot]) begin
                acc   = acc | hour_entry(i_slot);
                dwell = dwell + 4'd3;
            end
            if (i_slot < 4'd6 && show_tens && i_disp.minute_tens_mask[i_slot[2:0]]) begin
                acc   = acc | tens_entry(i_slot[2:0]);
                dwell = dwell + 4'd3;
            end
            if (show_ones && i_disp.minute_ones_mask[i_slot]) begin
                acc   = acc | ones_entry(i_slot);
                dwell = dwell + 4'd3;
            end
        end
    end

    assign o_scan.port1_level = acc[31:24];
    assign o_scan.port2_level = acc[23:16];
    assign o_scan.port1_drive = acc[15:8];
    assign o_scan.port2_drive = acc[7:0];
    assign o_scan.dwell       = dwell;

endmodule

[hdl/ulcc_state.sv]
`timescale 1ns / 1ps

module ulcc_state (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  ulcc_pkg::t_item   i_item,
    input  ulcc_pkg::t_cfg    i_cfg,
    output ulcc_pkg::t_disp   o_disp,
    output ulcc_pkg::t_status o_next
);
    import ulcc_pkg::*;

    // Time of day is kept as digits, so no division is needed to show it.
    logic [5:0] r_second, n_second;
    logic [3:0] r_hour, n_hour;
    logic [2:0] r_tens, n_tens;
    logic [3:0] r_ones, n_ones;
    logic [7:0] r_countdown, n_countdown;
    t_disp      r_disp, n_disp;

    function automatic logic [8:0] unary9(input logic [3:0] n);
        logic [9:0] v;
        v = (10'd1 << n) - 10'd1;
        return v[8:0];
    endfunction

    function automatic logic [5:0] unary6(input logic [2:0] n);
        logic [6:0] v;
        v = (7'd1 << n) - 7'd1;
        return v[5:0];
    endfunction

    always_comb begin
        logic       rebuild;
        logic [3:0] hour_digit;
        n_second    = r_second;
        n_hour      = r_hour;
        n_tens      = r_tens;
        n_ones      = r_ones;
        n_countdown = r_countdown;
        n_disp      = r_disp;
        rebuild     = 1'b0;
        hour_digit  = 4'd0;
        if (i_fire) begin
            unique case (i_item.req_type)
                REQ_TICK: begin
                    if (r_second == 6'd59) begin
                        n_second = 6'd0;
                        rebuild  = 1'b1;
                        if (r_ones != 4'd9) begin
                            n_ones = r_ones + 4'd1;
                        end else begin
                            n_ones = 4'd0;
                            if (r_tens != 3'd5) begin
                                n_tens = r_tens + 3'd1;
                            end else begin
                                n_tens = 3'd0;
                                n_hour = (r_hour == 4'd11) ? 4'd0 : r_hour + 4'd1;
                            end
                        end
                    end else begin
                        n_second = r_second + 6'd1;
                        if (r_disp.set_mode == MODE_RUN && !r_disp.asleep) begin
                            n_disp.hour_mask = {r_disp.hour_mask[7:0], r_disp.hour_mask[8]};
                            n_disp.minute_tens_mask = {r_disp.minute_tens_mask[4:0],
                                                       r_disp.minute_tens_mask[5]};
                            n_disp.minute_ones_mask = {r_disp.minute_ones_mask[7:0],
                                                       r_disp.minute_ones_mask[8]};
                            if (r_countdown != 8'd0) begin
                                n_countdown = r_countdown - 8'd1;
                            end else begin
                                n_disp.asleep = 1'b1;
                            end
                        end
                    end
                end
                REQ_PRESS: begin
                    priority if (r_disp.asleep) begin
                        // Any release only wakes the display.
                        n_disp.asleep = 1'b0;
                        n_countdown   = i_cfg.auto_sleep_seconds;
                        rebuild       = 1'b1;
                    end else if (i_item.press_length <= i_cfg.debounce_min) begin
                        n_countdown = r_countdown;
                    end else if (i_item.press_length > i_cfg.long_press_min) begin
                        n_disp.set_mode = r_disp.set_mode + 2'd1;
                        n_countdown     = i_cfg.auto_sleep_seconds;
                    end else begin
                        unique case (r_disp.set_mode)
                            MODE_RUN: begin
                                n_countdown = r_countdown + i_cfg.auto_sleep_seconds;
                            end
                            MODE_HOUR: begin
                                n_hour  = (r_hour == 4'd11) ? 4'd0 : r_hour + 4'd1;
                                rebuild = 1'b1;
                            end
                            MODE_TENS: begin
                                n_tens  = (r_tens == 3'd5) ? 3'd0 : r_tens + 3'd1;
                                rebuild = 1'b1;
                            end
                            MODE_ONES: begin
                                n_ones  = (r_ones == 4'd9) ? 4'd0 : r_ones + 4'd1;
                                rebuild = 1'b1;
                            end
                        endcase
                    end
                end
                default: begin
                    // Scans and the unused code leave the state alone.
                    n_second = r_second;
                end
            endcase
        end
        if (rebuild) begin
            // Hour zero reads as twelve: tens lamp plus two.
            if (n_hour == 4'd0) begin
                hour_digit = 4'd2;
            end else if (n_hour >= 4'd10) begin
                hour_digit = n_hour - 4'd10;
            end else begin
                hour_digit = n_hour;
            end
            n_disp.hour_tens_lit    = (n_hour >= 4'd10) || (n_hour == 4'd0);
            n_disp.hour_mask        = unary9(hour_digit);
            n_disp.minute_tens_mask = unary6(n_tens);
            n_disp.minute_ones_mask = unary9(n_ones);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second                <= 6'd30;
            r_hour                  <= 4'd4;
            r_tens                  <= 3'd5;
            r_ones                  <= 4'd3;
            r_countdown             <= AUTO_SLEEP_RESET;
            r_disp.hour_tens_lit    <= 1'b0;
            r_disp.hour_mask        <= 9'h00F;
            r_disp.minute_tens_mask <= 6'h1F;
            r_disp.minute_ones_mask <= 9'h007;
            r_disp.asleep           <= 1'b0;
            r_disp.set_mode         <= MODE_RUN;
        end else begin
            r_second    <= n_second;
            r_hour      <= n_hour;
            r_tens      <= n_tens;
            r_ones      <= n_ones;
            r_countdown <= n_countdown;
            r_disp      <= n_disp;
        end
    end

    assign o_disp          = r_disp;
    assign o_next.asleep   = n_disp.asleep;
    assign o_next.set_mode = n_disp.set_mode;

endmodule

[hdl/unary_led_clock_controller.sv]
`timescale 1ns / 1ps

// Channel  | Direction | Handshake           | Payload
// input    | in        | i_valid / o_ready   | req_type, press_length, slot, blink_phase
// result   | out       | o_valid / i_ready   | port levels, drives, dwell, sleeping, mode
// config   | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
// A result passes from the input register to the result register. The item
// sits in the input register while the step logic works on it, and the
// result register loads when the step logic fires.
// One item is accepted per cycle while the result side keeps up; the single
// state update per cycle sets that figure.
// Reset is synchronous and active low; it restores the time to 4:53:30, run
// mode, awake, and the configuration registers to their defaults.
// A stalled result holds the result register, and the input register then
// holds one more item before o_ready drops.

module unary_led_clock_controller (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration write port
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // Input items
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_press_length,
    input  logic [3:0] i_slot,
    input  logic       i_blink_phase,
    // Result items
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_port1_level,
    output logic [7:0] o_port2_level,
    output logic [7:0] o_port1_drive,
    output logic [7:0] o_port2_drive,
    output logic [3:0] o_dwell,
    output logic       o_sleeping,
    output logic [1:0] o_current_mode
);
    import ulcc_pkg::*;

    `include "unary_led_clock_controller_assert.svh"

    // Configuration registers. Writes must arrive only while the block is idle; the block does not enforce this.
    t_cfg    r_cfg;

    // Input register: one item waiting for the step logic.
    logic    r_in_valid;
    t_item   r_in;

    // Result register.
    logic    r_out_valid;
    t_scan   r_out;
    t_status r_out_status;

    logic    fire;
    t_disp   disp;
    t_status next_status;
    t_scan   scan;
    t_scan   result;

    // The step logic runs when an item waits and the result register is free
    // or is emptied in this cycle.
    assign fire    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.auto_sleep_seconds <= AUTO_SLEEP_RESET;
            r_cfg.debounce_min       <= DEBOUNCE_RESET;
            r_cfg.long_press_min     <= LONG_PRESS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_AUTO_SLEEP: r_cfg.auto_sleep_seconds <= i_cfg_data;
                CFG_DEBOUNCE:   r_cfg.debounce_min       <= i_cfg_data;
                CFG_LONG_PRESS: r_cfg.long_press_min     <= i_cfg_data;
                default:        r_cfg                    <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in.req_type     <= i_req_type;
            r_in.press_length <= i_press_length;
            r_in.slot         <= i_slot;
            r_in.blink_phase  <= i_blink_phase;
        end
    end

    ulcc_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_disp  (disp),
        .o_next  (next_status)
    );

    ulcc_scan u_scan (
        .i_slot        (r_in.slot),
        .i_blink_phase (r_in.blink_phase),
        .i_disp        (disp),
        .o_scan        (scan)
    );

    // Only scan items carry port data; every other item reports zeros.
    assign result = (r_in.req_type == REQ_SCAN) ? scan : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out        <= result;
            r_out_status <= next_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_port1_level  = r_out.port1_level;
    assign o_port2_level  = r_out.port2_level;
    assign o_port1_drive  = r_out.port1_drive;
    assign o_port2_drive  = r_out.port2_drive;
    assign o_dwell        = r_out.dwell;
    assign o_sleeping     = r_out_status.asleep;
    assign o_current_mode = r_out_status.set_mode;

    // Dwell is three per lit group, at most three groups.
    `ULCC_ASSERT_ALWAYS(a_dwell_steps, i_clk, i_rst_n, !r_out_valid || r_out.dwell == 4'd0 || r_out.dwell == 4'd3 || r_out.dwell == 4'd6 || r_out.dwell == 4'd9)

    // A sleeping display never drives a lamp.
    `ULCC_ASSERT_ALWAYS(a_sleep_dark, i_clk, i_rst_n, !(r_out_valid && r_out_status.asleep) || (r_out.port1_drive == 8'd0 && r_out.port2_drive == 8'd0 && r_out.dwell == 4'd0))

    // Back-pressure on the input side only comes from a full input register behind a stalled result.
    `ULCC_ASSERT_ALWAYS(a_ready_cause, i_clk, i_rst_n, o_ready || (r_in_valid && r_out_valid && !i_ready))

    // A result that is not taken stays in the result register.
    `ULCC_ASSERT_NEXT(a_result_kept, i_clk, i_rst_n, r_out_valid && !i_ready, r_out_valid)

endmodule
